/* rtl/core/jbl_pkg.sv */
// shared types, codes and character tables for the json byte lexer
// no dependencies; used by every module of the block by scoped name
package jbl_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  // token types
  localparam logic [3:0] TT_COLON    = 4'd0;
  localparam logic [3:0] TT_COMMA    = 4'd1;
  localparam logic [3:0] TT_LBRACE   = 4'd2;
  localparam logic [3:0] TT_RBRACE   = 4'd3;
  localparam logic [3:0] TT_LBRACKET = 4'd4;
  localparam logic [3:0] TT_RBRACKET = 4'd5;
  localparam logic [3:0] TT_FALSE    = 4'd6;
  localparam logic [3:0] TT_NULL     = 4'd7;
  localparam logic [3:0] TT_TRUE     = 4'd8;
  localparam logic [3:0] TT_NUMBER   = 4'd9;
  localparam logic [3:0] TT_STRING   = 4'd10;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_DIGIT      = 2'd2;
  localparam logic [1:0] ERR_CONTROL    = 2'd3;

  // keyword selects
  localparam logic [1:0] KW_FALSE = 2'd0;
  localparam logic [1:0] KW_NULL  = 2'd1;
  localparam logic [1:0] KW_TRUE  = 2'd2;

  localparam logic [7:0] UNICODE_SUB = 8'h3f;
  localparam logic [2:0] HEX_DIGITS = 3'd4;

  typedef enum logic [12:0] {
    M_IDLE   = 13'b0000000000001,
    M_KW     = 13'b0000000000010,
    M_NSIGN  = 13'b0000000000100,
    M_NZERO  = 13'b0000000001000,
    M_NINT   = 13'b0000000010000,
    M_NFRAC0 = 13'b0000000100000,
    M_NFRAC  = 13'b0000001000000,
    M_NEXP0  = 13'b0000010000000,
    M_NEXPS  = 13'b0000100000000,
    M_NEXP   = 13'b0001000000000,
    M_STR    = 13'b0010000000000,
    M_ESC    = 13'b0100000000000,
    M_HEX    = 13'b1000000000000
  } mode_t;

  // one classified input byte
  typedef struct packed {
    logic [7:0]  c;
    logic [19:0] line;
    logic [15:0] col;
    logic        eoi;
    logic        is_digit;
    logic        is_hex;
    logic        is_ws;
    logic        is_punct;
    logic [3:0]  punct_type;
  } item_t;

  typedef struct packed {
    logic [3:0]  token_type;
    logic [7:0]  text_byte;
    logic        text_valid;
    logic        token_done;
    logic [1:0]  error_code;
    logic [19:0] token_line;
    logic [15:0] token_column;
    logic        last_of_run;
  } res_t;

  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (sel)
      KW_FALSE: begin
        case (pos)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KW_NULL: begin
        case (pos)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      KW_TRUE: begin
        case (pos)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    return (sel == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

/* rtl/core/jbl_front.sv */
// front end: takes input bytes, classifies them and holds them in a short queue
// depends on jbl_pkg
module jbl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    data_byte,
  input  logic [19:0]   line_in,
  input  logic [15:0]   col_in,
  input  logic          end_of_input,
  input  logic          push,
  output logic          full,
  output jbl_pkg::item_t head,
  output logic          head_valid,
  input  logic          take
);

  jbl_pkg::item_t q [jbl_pkg::QDEPTH];
  jbl_pkg::item_t cls;
  logic [jbl_pkg::QAW-1:0] wp;
  logic [jbl_pkg::QAW-1:0] rp;
  logic [jbl_pkg::QCW-1:0] cnt;
  logic do_push;
  logic do_take;
  logic [7:0] c;

  always_comb begin
    // end of input reads as a nul byte
    c = end_of_input ? 8'h00 : data_byte;
    cls = '0;
    cls.c = c;
    cls.line = line_in;
    cls.col = col_in;
    cls.eoi = end_of_input;
    cls.is_digit = (c >= "0") && (c <= "9");
    cls.is_hex = cls.is_digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    cls.is_ws = (c == " ") || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
    cls.is_punct = 1'b1;
    case (c)
      ":": cls.punct_type = jbl_pkg::TT_COLON;
      ",": cls.punct_type = jbl_pkg::TT_COMMA;
      "{": cls.punct_type = jbl_pkg::TT_LBRACE;
      "}": cls.punct_type = jbl_pkg::TT_RBRACE;
      "[": cls.punct_type = jbl_pkg::TT_LBRACKET;
      "]": cls.punct_type = jbl_pkg::TT_RBRACKET;
      default: begin
        cls.is_punct = 1'b0;
        cls.punct_type = jbl_pkg::TT_COLON;
      end
    endcase
  end

  assign full = (cnt == jbl_pkg::QCW'(jbl_pkg::QDEPTH));
  assign head_valid = (cnt != '0);
  assign head = q[rp];
  assign do_push = push && !full;
  assign do_take = take && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_take) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + QCW_ONE(do_push) - QCW_ONE(do_take);
    end
  end

  function automatic logic [jbl_pkg::QCW-1:0] QCW_ONE(input logic b);
    return {{(jbl_pkg::QCW-1){1'b0}}, b};
  endfunction

endmodule

/* rtl/core/jbl_back.sv */
// back end: lexer state machine over classified bytes, plus the result queue
// depends on jbl_pkg; fed by jbl_front
module jbl_back (
  input  logic           clk,
  input  logic           rst,
  input  jbl_pkg::item_t head,
  input  logic           head_valid,
  output logic           take,
  input  logic           pop,
  output logic           empty,
  output jbl_pkg::res_t  res_head
);

  jbl_pkg::mode_t mode;
  jbl_pkg::mode_t mode_next;
  logic [1:0]  keyword_sel, keyword_sel_next;
  logic [2:0]  keyword_pos, keyword_pos_next;
  logic [2:0]  hex_count, hex_count_next;
  logic [19:0] start_line, start_line_next;
  logic [15:0] start_column, start_column_next;

  jbl_pkg::res_t rq [jbl_pkg::QDEPTH];
  logic [jbl_pkg::QAW-1:0] wp;
  logic [jbl_pkg::QAW-1:0] rp;
  logic [jbl_pkg::QCW-1:0] cnt;

  jbl_pkg::res_t r0, r1;
  logic [1:0] n;
  logic do_pop;

  // lexing of a byte from idle
  logic          il_emit;
  jbl_pkg::res_t il_res;
  jbl_pkg::mode_t il_mode;
  logic          il_kw;
  logic [1:0]    il_sel;

  logic [3:0] cur_type;
  logic [7:0] c;
  logic [2:0] pos_inc;
  logic [2:0] hex_inc;

  function automatic jbl_pkg::res_t mk(input logic [3:0] t, input logic [7:0] b,
                                       input logic v, input logic d, input logic [1:0] e,
                                       input logic [19:0] ln, input logic [15:0] cl);
    jbl_pkg::res_t r;
    r.token_type = t;
    r.text_byte = b;
    r.text_valid = v;
    r.token_done = d;
    r.error_code = e;
    r.token_line = ln;
    r.token_column = cl;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign c = head.c;
  assign pos_inc = keyword_pos + 3'd1;
  assign hex_inc = hex_count + 3'd1;

  always_comb begin
    case (mode)
      jbl_pkg::M_KW: cur_type = jbl_pkg::TT_FALSE + {2'b00, keyword_sel};
      jbl_pkg::M_NSIGN, jbl_pkg::M_NZERO, jbl_pkg::M_NINT, jbl_pkg::M_NFRAC0,
      jbl_pkg::M_NFRAC, jbl_pkg::M_NEXP0, jbl_pkg::M_NEXPS,
      jbl_pkg::M_NEXP: cur_type = jbl_pkg::TT_NUMBER;
      jbl_pkg::M_STR, jbl_pkg::M_ESC, jbl_pkg::M_HEX: cur_type = jbl_pkg::TT_STRING;
      default: cur_type = jbl_pkg::TT_COLON;
    endcase
  end

  always_comb begin
    il_emit = 1'b0;
    il_res = '0;
    il_mode = jbl_pkg::M_IDLE;
    il_kw = 1'b0;
    il_sel = jbl_pkg::KW_FALSE;
    if (!head.is_ws) begin
      il_emit = 1'b1;
      if (head.is_punct) begin
        il_res = mk(head.punct_type, c, 1'b1, 1'b1, jbl_pkg::ERR_NONE, head.line, head.col);
      end else if (c == "f" || c == "n" || c == "t") begin
        il_kw = 1'b1;
        il_sel = (c == "f") ? jbl_pkg::KW_FALSE : ((c == "n") ? jbl_pkg::KW_NULL
                                                               : jbl_pkg::KW_TRUE);
        il_mode = jbl_pkg::M_KW;
        il_res = mk(jbl_pkg::TT_FALSE + {2'b00, il_sel}, c, 1'b1, 1'b0, jbl_pkg::ERR_NONE,
                    head.line, head.col);
      end else if (c == "-" || head.is_digit) begin
        il_mode = (c == "-") ? jbl_pkg::M_NSIGN
                             : ((c == "0") ? jbl_pkg::M_NZERO : jbl_pkg::M_NINT);
        il_res = mk(jbl_pkg::TT_NUMBER, c, 1'b1, 1'b0, jbl_pkg::ERR_NONE, head.line, head.col);
      end else if (c == "\"") begin
        // opening quote starts a string with no result
        il_emit = 1'b0;
        il_mode = jbl_pkg::M_STR;
      end else begin
        il_res = mk(jbl_pkg::TT_COLON, c, 1'b0, 1'b0, jbl_pkg::ERR_UNEXPECTED,
                    head.line, head.col);
      end
    end
  end

  always_comb begin
    logic fail;
    logic [1:0] fail_code;
    logic num_ok;
    logic num_end;
    jbl_pkg::mode_t num_next;
    fail = 1'b0;
    fail_code = jbl_pkg::ERR_NONE;
    num_ok = 1'b0;
    num_end = 1'b0;
    num_next = jbl_pkg::M_IDLE;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    mode_next = mode;
    keyword_sel_next = keyword_sel;
    keyword_pos_next = keyword_pos;
    hex_count_next = hex_count;
    start_line_next = start_line;
    start_column_next = start_column;

    case (mode)
      jbl_pkg::M_KW: begin
        if (c != jbl_pkg::kw_char(keyword_sel, keyword_pos)) begin
          fail = 1'b1;
          fail_code = jbl_pkg::ERR_UNEXPECTED;
        end else begin
          keyword_pos_next = pos_inc;
          n = 2'd1;
          if (pos_inc == jbl_pkg::kw_len(keyword_sel)) begin
            r0 = mk(cur_type, c, 1'b1, 1'b1, jbl_pkg::ERR_NONE, start_line, start_column);
            mode_next = jbl_pkg::M_IDLE;
          end else begin
            r0 = mk(cur_type, c, 1'b1, 1'b0, jbl_pkg::ERR_NONE, start_line, start_column);
          end
        end
      end
      jbl_pkg::M_NSIGN: begin
        if (head.is_digit) begin
          num_ok = 1'b1;
          num_next = (c == "0") ? jbl_pkg::M_NZERO : jbl_pkg::M_NINT;
        end else begin
          fail = 1'b1;
          fail_code = jbl_pkg::ERR_DIGIT;
        end
      end
      jbl_pkg::M_NZERO, jbl_pkg::M_NINT: begin
        if (head.is_digit && mode == jbl_pkg::M_NINT) begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NINT;
        end else if (c == ".") begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NFRAC0;
        end else if (c == "e" || c == "E") begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NEXP0;
        end else begin
          num_end = 1'b1;
        end
      end
      jbl_pkg::M_NFRAC0: begin
        if (head.is_digit) begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NFRAC;
        end else begin
          fail = 1'b1;
          fail_code = jbl_pkg::ERR_DIGIT;
        end
      end
      jbl_pkg::M_NFRAC: begin
        if (head.is_digit) begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NFRAC;
        end else if (c == "e" || c == "E") begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NEXP0;
        end else begin
          num_end = 1'b1;
        end
      end
      jbl_pkg::M_NEXP0: begin
        if (head.is_digit) begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NEXP;
        end else if (c == "+" || c == "-") begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NEXPS;
        end else begin
          fail = 1'b1;
          fail_code = jbl_pkg::ERR_DIGIT;
        end
      end
      jbl_pkg::M_NEXPS: begin
        if (head.is_digit) begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NEXP;
        end else begin
          fail = 1'b1;
          fail_code = jbl_pkg::ERR_DIGIT;
        end
      end
      jbl_pkg::M_NEXP: begin
        if (head.is_digit) begin
          num_ok = 1'b1;
          num_next = jbl_pkg::M_NEXP;
        end else begin
          num_end = 1'b1;
        end
      end
      jbl_pkg::M_STR: begin
        if (head.eoi || c < 8'h20) begin
          fail = 1'b1;
          fail_code = jbl_pkg::ERR_CONTROL;
        end else if (c == "\"") begin
          n = 2'd1;
          r0 = mk(jbl_pkg::TT_STRING, 8'h00, 1'b0, 1'b1, jbl_pkg::ERR_NONE,
                  start_line, start_column);
          mode_next = jbl_pkg::M_IDLE;
        end else if (c == "\\") begin
          mode_next = jbl_pkg::M_ESC;
        end else begin
          n = 2'd1;
          r0 = mk(jbl_pkg::TT_STRING, c, 1'b1, 1'b0, jbl_pkg::ERR_NONE,
                  start_line, start_column);
        end
      end
      jbl_pkg::M_ESC: begin
        logic [7:0] v;
        logic ok;
        ok = 1'b1;
        v = c;
        case (c)
          "b": v = 8'h08;
          "f": v = 8'h0c;
          "n": v = 8'h0a;
          "r": v = 8'h0d;
          "t": v = 8'h09;
          "\"", "\\", "/": v = c;
          "u": ok = 1'b0;
          default: begin
            ok = 1'b0;
            fail = 1'b1;
            fail_code = jbl_pkg::ERR_UNEXPECTED;
          end
        endcase
        if (ok) begin
          n = 2'd1;
          r0 = mk(jbl_pkg::TT_STRING, v, 1'b1, 1'b0, jbl_pkg::ERR_NONE,
                  start_line, start_column);
          mode_next = jbl_pkg::M_STR;
        end else if (!fail) begin
          hex_count_next = 3'd0;
          mode_next = jbl_pkg::M_HEX;
        end
      end
      jbl_pkg::M_HEX: begin
        if (!head.is_hex) begin
          fail = 1'b1;
          fail_code = jbl_pkg::ERR_DIGIT;
        end else if (hex_inc >= jbl_pkg::HEX_DIGITS) begin
          n = 2'd1;
          r0 = mk(jbl_pkg::TT_STRING, jbl_pkg::UNICODE_SUB, 1'b1, 1'b0, jbl_pkg::ERR_NONE,
                  start_line, start_column);
          hex_count_next = 3'd0;
          mode_next = jbl_pkg::M_STR;
        end else begin
          hex_count_next = hex_inc;
        end
      end
      default: begin
        mode_next = jbl_pkg::M_IDLE;
        if (!head.eoi) begin
          if (!head.is_ws) begin
            start_line_next = head.line;
            start_column_next = head.col;
          end
          if (il_kw) begin
            keyword_sel_next = il_sel;
            keyword_pos_next = 3'd1;
          end
          mode_next = il_mode;
          if (il_emit) begin
            n = 2'd1;
            r0 = il_res;
          end
        end
      end
    endcase

    if (num_ok) begin
      n = 2'd1;
      r0 = mk(jbl_pkg::TT_NUMBER, c, 1'b1, 1'b0, jbl_pkg::ERR_NONE, start_line, start_column);
      mode_next = num_next;
    end

    // the byte that ends a number is lexed again from idle
    if (num_end) begin
      n = 2'd1;
      r0 = mk(jbl_pkg::TT_NUMBER, 8'h00, 1'b0, 1'b1, jbl_pkg::ERR_NONE,
              start_line, start_column);
      mode_next = jbl_pkg::M_IDLE;
      if (!head.eoi) begin
        if (!head.is_ws) begin
          start_line_next = head.line;
          start_column_next = head.col;
        end
        if (il_kw) begin
          keyword_sel_next = il_sel;
          keyword_pos_next = 3'd1;
        end
        mode_next = il_mode;
        if (il_emit) begin
          n = 2'd2;
          r1 = il_res;
        end
      end
    end

    if (fail) begin
      n = 2'd1;
      r0 = mk(cur_type, c, 1'b0, 1'b0, fail_code, start_line, start_column);
      mode_next = jbl_pkg::M_IDLE;
    end

    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end else begin
      r0.last_of_run = 1'b1;
    end
  end

  // an item is taken only when the result queue has room for two results
  assign take = head_valid && (cnt <= jbl_pkg::QCW'(jbl_pkg::QDEPTH - 2));
  assign empty = (cnt == '0);
  assign res_head = rq[rp];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (take && n != 2'd0) begin
      rq[wp] <= r0;
    end
    if (take && n == 2'd2) begin
      rq[wp + 1'b1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jbl_pkg::M_IDLE;
      keyword_sel <= '0;
      keyword_pos <= '0;
      hex_count <= '0;
      start_line <= '0;
      start_column <= '0;
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (take) begin
        mode <= mode_next;
        keyword_sel <= keyword_sel_next;
        keyword_pos <= keyword_pos_next;
        hex_count <= hex_count_next;
        start_line <= start_line_next;
        start_column <= start_column_next;
        wp <= wp + jbl_pkg::QAW'(n);
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (take ? jbl_pkg::QCW'(n) : '0) - jbl_pkg::QCW'(do_pop);
    end
  end

endmodule

/* rtl/core/json_byte_lexer_top.sv */
// Streaming JSON lexer, one byte of text per clock while full is low. A byte
// is accepted when push is high and full is low; results come out oldest
// first while empty is low and leave on pop. A byte's first result passes
// the input queue and then the result queue. The block sustains one byte per
// clock as long as each byte makes at most one result and pop keeps up; a
// byte that closes a number and opens another token makes two, and the
// single read port of the result queue then drains them at one per clock,
// so a run of such bytes holds up the input. Whitespace between tokens and
// opening quotes make no result. Token start positions come from
// line_in/col_in of the token's first byte; after any error the lexer is
// back between tokens.
// depends on jbl_pkg, jbl_front, jbl_back
module json_byte_lexer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic [19:0] line_in,
  input  logic [15:0] col_in,
  input  logic        end_of_input,
  input  logic        push,
  output logic        full,
  output logic [3:0]  token_type,
  output logic [7:0]  text_byte,
  output logic        text_valid,
  output logic        token_done,
  output logic [1:0]  error_code,
  output logic [19:0] token_line,
  output logic [15:0] token_column,
  output logic        last_of_run,
  output logic        empty,
  input  logic        pop
);

  jbl_pkg::item_t head;
  logic head_valid;
  logic take;
  jbl_pkg::res_t res_head;

  jbl_front u_front (
    .clk(clk),
    .rst(rst),
    .data_byte(data_byte),
    .line_in(line_in),
    .col_in(col_in),
    .end_of_input(end_of_input),
    .push(push),
    .full(full),
    .head(head),
    .head_valid(head_valid),
    .take(take)
  );

  jbl_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .head_valid(head_valid),
    .take(take),
    .pop(pop),
    .empty(empty),
    .res_head(res_head)
  );

  assign token_type = res_head.token_type;
  assign text_byte = res_head.text_byte;
  assign text_valid = res_head.text_valid;
  assign token_done = res_head.token_done;
  assign error_code = res_head.error_code;
  assign token_line = res_head.token_line;
  assign token_column = res_head.token_column;
  assign last_of_run = res_head.last_of_run;

endmodule

/* rtl/core/jbl_checker.sv */
// port-level checks for json_byte_lexer_top, attached by bind
// depends on jbl_pkg
module jbl_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  token_type,
  input logic        text_valid,
  input logic        token_done,
  input logic [1:0]  error_code
);

  // both queues come out of reset empty
  a_reset_clear: assert property (@(posedge clk) rst |=> (!full && empty))
    else $error("queues not cleared by reset");

  // a waiting result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(token_type) && $stable(error_code)))
    else $error("waiting result changed");

  // errors never close a token nor carry text
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
      (!empty && error_code != jbl_pkg::ERR_NONE) |-> (!token_done && !text_valid))
    else $error("error result marked as text or done");

  // a done result without text only closes a number or a string
  a_bare_done: assert property (@(posedge clk) disable iff (rst)
      (!empty && token_done && !text_valid) |->
      (token_type == jbl_pkg::TT_NUMBER || token_type == jbl_pkg::TT_STRING))
    else $error("bare done on wrong token type");

  // text with done only ends punctuation or keywords
  a_text_done: assert property (@(posedge clk) disable iff (rst)
      (!empty && token_done && text_valid) |-> (token_type <= jbl_pkg::TT_TRUE))
    else $error("text on done of number or string");

endmodule

bind json_byte_lexer_top jbl_checker u_jbl_checker (
  .clk(clk),
  .rst(rst),
  .full(full),
  .empty(empty),
  .pop(pop),
  .token_type(token_type),
  .text_valid(text_valid),
  .token_done(token_done),
  .error_code(error_code)
);
